@@ hdl/rbst_pkg.sv @@
// Shared widths, latencies, register indexes and lane types for the ray/box slab test.
`timescale 1ns / 1ps
`default_nettype none
package rbst_pkg;

    // Coordinate format: signed Q16.16.
    localparam int COORD_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int SCALE_W  = COORD_W - 1;
    localparam int PROD_W   = 2 * SCALE_W;
    localparam int CTR_W    = COORD_W + 1;
    localparam int BND_W    = COORD_W + 2;
    localparam int DIFF_W   = COORD_W + 3;
    localparam int NUM_W    = DIFF_W + FRAC_W;
    localparam int T_W      = NUM_W + 1;
    localparam int REM_W    = COORD_W + 1;
    localparam int NUM_AXES = 3;

    // Latencies: divider is an input stage, one stage per quotient bit and a sign stage.
    localparam int DIV_LAT  = NUM_W + 2;
    localparam int LANE_LAT = 3 + DIV_LAT;
    localparam int PIPE_LAT = LANE_LAT + 2;

    localparam int CFG_ADDR_W = 3;

    localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};
    localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } cfg_reg_t;

    // Slab parameters one lane hands to the merge stage.
    typedef struct packed {
        logic signed [T_W-1:0] t_lo;
        logic signed [T_W-1:0] t_hi;
        logic                  par_ok;
    } lane_res_t;

    // Combined entry/exit over all axes.
    typedef struct packed {
        logic signed [T_W-1:0] t_ent;
        logic signed [T_W-1:0] t_ext;
        logic                  fail;
    } merge_res_t;

endpackage
`default_nettype wire

@@ hdl/rbst_div.sv @@
// Pipelined signed divider, one restoring quotient bit per stage, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module rbst_div (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic signed [rbst_pkg::NUM_W-1:0]   num,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] den,
    output logic signed [rbst_pkg::T_W-1:0]          quo
);

    localparam int NW = rbst_pkg::NUM_W;
    localparam int DW = rbst_pkg::COORD_W;
    localparam int RW = rbst_pkg::REM_W;

    logic [NW-1:0] nq_reg  [0:NW];
    logic [RW-1:0] rem_reg [0:NW];
    logic [DW-1:0] d_reg   [0:NW];
    logic          neg_reg [0:NW];
    logic signed [rbst_pkg::T_W-1:0] quo_reg;

    logic [NW-1:0] mag_n;
    logic [DW-1:0] mag_d;

    // Split operands into magnitude and result sign.
    assign mag_n = num[NW-1] ? (~num + NW'(1)) : num;
    assign mag_d = den[DW-1] ? (~den + DW'(1)) : den;

    always_ff @(posedge aclk) begin
        if (en) begin
            nq_reg[0]  <= mag_n;
            rem_reg[0] <= '0;
            d_reg[0]   <= mag_d;
            neg_reg[0] <= num[NW-1] ^ den[DW-1];
        end
    end

    // One quotient bit per stage: shift in the next numerator bit and trial subtract.
    for (genvar k = 0; k < NW; k++) begin : g_step
        logic [RW-1:0] shifted;
        logic [RW:0]   trial;
        logic          fits;

        always_comb begin
            shifted = {rem_reg[k][RW-2:0], nq_reg[k][NW-1]};
            trial   = {1'b0, shifted} - (RW+1)'(d_reg[k]);
            fits    = ~trial[RW];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= fits ? trial[RW-1:0] : shifted;
                nq_reg[k+1]  <= {nq_reg[k][NW-2:0], fits};
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    // Restore the sign of the quotient.
    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= neg_reg[NW] ? -$signed({1'b0, nq_reg[NW]}) : $signed({1'b0, nq_reg[NW]});
        end
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

@@ hdl/rbst_lane.sv @@
// One axis lane: box bounds, parallel check and the two slab parameters.
`timescale 1ns / 1ps
`default_nettype none
module rbst_lane (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] pos,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] off,
    input  wire logic        [rbst_pkg::SCALE_W-1:0] scale_a,
    input  wire logic        [rbst_pkg::SCALE_W-1:0] scale_b,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] origin,
    input  wire logic signed [rbst_pkg::COORD_W-1:0] dir,
    output rbst_pkg::lane_res_t                      res
);

    localparam int SW = rbst_pkg::SCALE_W;
    localparam int PW = rbst_pkg::PROD_W;
    localparam int BW = rbst_pkg::BND_W;
    localparam int DF = rbst_pkg::DIFF_W;
    localparam int NW = rbst_pkg::NUM_W;
    localparam int DL = rbst_pkg::DIV_LAT;

    logic        [PW-1:0]              prod_reg;
    logic signed [rbst_pkg::CTR_W-1:0] ctr_reg;
    logic signed [BW-1:0]              lo_reg;
    logic signed [BW-1:0]              hi_reg;
    logic signed [NW-1:0]              num_lo_reg;
    logic signed [NW-1:0]              num_hi_reg;
    logic                              par_ok_reg [0:DL];

    logic [PW-1:0] half_full;
    logic [SW-1:0] half;
    logic signed [BW-1:0] org_b;
    logic signed [DF-1:0] diff_lo;
    logic signed [DF-1:0] diff_hi;

    // Size product and center.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PW'(scale_a) * PW'(scale_b);
            ctr_reg  <= rbst_pkg::CTR_W'(pos) + rbst_pkg::CTR_W'(off);
        end
    end

    // Half size, saturated, and the bounds.
    always_comb begin
        half_full = prod_reg >> (rbst_pkg::FRAC_W + 1);
        half      = (|half_full[PW-1:SW]) ? {SW{1'b1}} : half_full[SW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg <= BW'(ctr_reg) - $signed(BW'(half));
            hi_reg <= BW'(ctr_reg) + $signed(BW'(half));
        end
    end

    // Offsets from the origin, scaled to fixed point, and the parallel-axis test.
    always_comb begin
        org_b   = BW'(origin);
        diff_lo = DF'(lo_reg) - DF'(origin);
        diff_hi = DF'(hi_reg) - DF'(origin);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_lo_reg    <= {diff_lo, {rbst_pkg::FRAC_W{1'b0}}};
            num_hi_reg    <= {diff_hi, {rbst_pkg::FRAC_W{1'b0}}};
            par_ok_reg[0] <= (org_b >= lo_reg) && (org_b <= hi_reg);
        end
    end

    // Carry the parallel-axis verdict alongside the dividers.
    for (genvar k = 0; k < DL; k++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (en) begin
                par_ok_reg[k+1] <= par_ok_reg[k];
            end
        end
    end

    rbst_div u_div_lo (
        .aclk (aclk),
        .en   (en),
        .num  (num_lo_reg),
        .den  (dir),
        .quo  (res.t_lo)
    );

    rbst_div u_div_hi (
        .aclk (aclk),
        .en   (en),
        .num  (num_hi_reg),
        .den  (dir),
        .quo  (res.t_hi)
    );

    assign res.par_ok = par_ok_reg[DL];

endmodule
`default_nettype wire

@@ hdl/rbst_merge.sv @@
// Merge stage: sorts each lane's slab, then takes the latest entry and earliest exit.
`timescale 1ns / 1ps
`default_nettype none
module rbst_merge (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  rbst_pkg::lane_res_t                      lane [rbst_pkg::NUM_AXES],
    input  wire logic [rbst_pkg::NUM_AXES-1:0]       dir_zero,
    output rbst_pkg::merge_res_t                     res
);

    localparam int NA = rbst_pkg::NUM_AXES;
    localparam int TW = rbst_pkg::T_W;

    logic signed [TW-1:0] ent_reg [NA];
    logic signed [TW-1:0] ext_reg [NA];
    logic [NA-1:0]        fail_reg;
    rbst_pkg::merge_res_t res_reg;
    rbst_pkg::merge_res_t res_next;

    // Per lane: order the slab; a parallel axis only contributes its inside test.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                if (dir_zero[i]) begin
                    ent_reg[i]  <= rbst_pkg::T_MIN;
                    ext_reg[i]  <= rbst_pkg::T_MAX;
                    fail_reg[i] <= ~lane[i].par_ok;
                end else begin
                    ent_reg[i]  <= (lane[i].t_lo < lane[i].t_hi) ? lane[i].t_lo : lane[i].t_hi;
                    ext_reg[i]  <= (lane[i].t_lo < lane[i].t_hi) ? lane[i].t_hi : lane[i].t_lo;
                    fail_reg[i] <= 1'b0;
                end
            end
        end
    end

    // Across lanes: largest entry, smallest exit.
    always_comb begin
        res_next.t_ent = ent_reg[0];
        res_next.t_ext = ext_reg[0];
        for (int i = 1; i < NA; i++) begin
            if (ent_reg[i] > res_next.t_ent) begin
                res_next.t_ent = ent_reg[i];
            end
            if (ext_reg[i] < res_next.t_ext) begin
                res_next.t_ext = ext_reg[i];
            end
        end
        res_next.fail = |fail_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

@@ hdl/ray_box_slab_test_core.sv @@
// Top level of the ray/box slab test: configuration, lanes, merge and output register.
//
// Each input beat carries one box and yields one hit beat, tested against the line held in
// the configuration registers. The pipeline takes one box per clock while not stalled and
// has 3 bound stages, 53 divider stages and 2 merge stages ahead of the output register;
// the divider, one quotient bit per stage, sets the depth. Three axis lanes run side by
// side, each with two dividers. The pipe keeps advancing while a result waits as long as
// its last stage is empty; it stalls only when a second result would overrun the output
// register. Write the configuration only when no box is in flight.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_test_core (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,

    input  wire logic                                      cfg_wen,
    input  wire logic [rbst_pkg::CFG_ADDR_W-1:0]           cfg_addr,
    input  wire logic [rbst_pkg::COORD_W-1:0]              cfg_wdata,

    input  wire logic                                      s_valid,
    output logic                                           s_ready,
    input  wire logic signed [rbst_pkg::COORD_W-1:0]       s_obj_pos_x,
    input  wire logic signed [rbst_pkg::COORD_W-1:0]       s_obj_pos_y,
    input  wire logic signed [rbst_pkg::COORD_W-1:0]       s_obj_pos_z,
    input  wire logic signed [rbst_pkg::COORD_W-1:0]       s_offset_x,
    input  wire logic signed [rbst_pkg::COORD_W-1:0]       s_offset_y,
    input  wire logic signed [rbst_pkg::COORD_W-1:0]       s_offset_z,
    input  wire logic [rbst_pkg::SCALE_W-1:0]              s_obj_scale_x,
    input  wire logic [rbst_pkg::SCALE_W-1:0]              s_obj_scale_y,
    input  wire logic [rbst_pkg::SCALE_W-1:0]              s_obj_scale_z,
    input  wire logic [rbst_pkg::SCALE_W-1:0]              s_box_scale_x,
    input  wire logic [rbst_pkg::SCALE_W-1:0]              s_box_scale_y,
    input  wire logic [rbst_pkg::SCALE_W-1:0]              s_box_scale_z,

    output logic                                           m_valid,
    input  wire logic                                      m_ready,
    output logic                                           m_hit
);

    localparam int NA = rbst_pkg::NUM_AXES;
    localparam int CW = rbst_pkg::COORD_W;
    localparam int PL = rbst_pkg::PIPE_LAT;

    logic signed [CW-1:0] origin_reg [NA];
    logic signed [CW-1:0] dir_reg    [NA];
    logic [PL-1:0]        vld_reg;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic                 hit_reg;
    logic                 en;

    logic signed [CW-1:0]          pos    [NA];
    logic signed [CW-1:0]          off    [NA];
    logic [rbst_pkg::SCALE_W-1:0]  sc_obj [NA];
    logic [rbst_pkg::SCALE_W-1:0]  sc_box [NA];
    logic [NA-1:0]                 dir_zero;
    rbst_pkg::lane_res_t           lane_res [NA];
    rbst_pkg::merge_res_t          mrg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NA; i++) begin
                origin_reg[i] <= '0;
                dir_reg[i]    <= '0;
            end
        end else if (cfg_wen) begin
            unique case (rbst_pkg::cfg_reg_t'(cfg_addr))
                rbst_pkg::REG_ORIGIN_X: origin_reg[0] <= cfg_wdata;
                rbst_pkg::REG_ORIGIN_Y: origin_reg[1] <= cfg_wdata;
                rbst_pkg::REG_ORIGIN_Z: origin_reg[2] <= cfg_wdata;
                rbst_pkg::REG_DIR_X:    dir_reg[0]    <= cfg_wdata;
                rbst_pkg::REG_DIR_Y:    dir_reg[1]    <= cfg_wdata;
                rbst_pkg::REG_DIR_Z:    dir_reg[2]    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline advance: stall only if the last stage holds a result the output cannot take.
    assign en      = ~vld_reg[PL-1] | ~out_vld_reg | m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PL-2:0], s_valid};
        end
    end

    // Output register.
    always_comb begin
        out_vld_next = out_vld_reg;
        if (!out_vld_reg || m_ready) begin
            out_vld_next = vld_reg[PL-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_ready) begin
            hit_reg <= ~mrg.fail && (mrg.t_ent < mrg.t_ext);
        end
    end

    assign m_valid = out_vld_reg;
    assign m_hit   = hit_reg;

    // Per-axis operands.
    assign pos    = '{s_obj_pos_x, s_obj_pos_y, s_obj_pos_z};
    assign off    = '{s_offset_x, s_offset_y, s_offset_z};
    assign sc_obj = '{s_obj_scale_x, s_obj_scale_y, s_obj_scale_z};
    assign sc_box = '{s_box_scale_x, s_box_scale_y, s_box_scale_z};

    for (genvar a = 0; a < NA; a++) begin : g_lane
        assign dir_zero[a] = (dir_reg[a] == '0);

        rbst_lane u_lane (
            .aclk    (aclk),
            .en      (en),
            .pos     (pos[a]),
            .off     (off[a]),
            .scale_a (sc_obj[a]),
            .scale_b (sc_box[a]),
            .origin  (origin_reg[a]),
            .dir     (dir_reg[a]),
            .res     (lane_res[a])
        );
    end

    rbst_merge u_merge (
        .aclk     (aclk),
        .en       (en),
        .lane     (lane_res),
        .dir_zero (dir_zero),
        .res      (mrg)
    );

`ifndef ASSERT_OFF
    // Input is refused only while a finished result is blocked at the output.
    a_ready_only_on_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && vld_reg[PL-1]))
        else $error("input stalled without a blocked result");

    // An accepted beat enters the first pipeline stage.
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted beat lost at pipeline entry");

    // A result held in the last stage during a stall is not dropped.
    a_last_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[PL-1] && !en) |=> vld_reg[PL-1])
        else $error("stalled result lost in pipeline");

    // The last stage moving on always lands in the output register.
    a_last_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[PL-1] && en) |=> m_valid)
        else $error("result lost between pipeline and output");
`endif

endmodule
`default_nettype wire
